// ----- hdl/insertion_sort_engine_defines.svh -----
// Assertion macros used by the sorter's top-level RTL file.
`ifndef INSERTION_SORT_ENGINE_DEFINES_SVH
`define INSERTION_SORT_ENGINE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define ISE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define ISE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/ise_pkg.sv -----
// Shared constants and types for the insertion sort engine.
`timescale 1ns / 1ps

package ise_pkg;

  localparam int DATA_W       = 32;
  localparam int ISE_CAPACITY = 32;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

  // What a cell shows its neighbours.
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     occ;
    logic                     gt;
  } cell_link_t;

endpackage

// ----- hdl/ise_cell.sv -----
// One cell of the sorting chain: holds a value and its occupied bit.
`timescale 1ns / 1ps

module ise_cell import ise_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  cell_ctrl_t               ctrl,
  input  logic signed [DATA_W-1:0] din,
  input  cell_link_t               left,
  input  cell_link_t               right,
  output cell_link_t               link
);

  logic signed [DATA_W-1:0] value;
  logic                     occ;
  logic                     gt;
  logic                     take;

  // Strictly greater only: equal values keep arrival order.
  assign gt   = occ && (value > din);
  // Take a value if this entry moves down, or if it is the first free slot.
  assign take = gt || (!occ && left.occ);

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (ctrl.shift) begin
      occ <= right.occ;
    end else if (ctrl.insert && take) begin
      occ <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      value <= right.value;
    end else if (ctrl.insert && take) begin
      value <= left.gt ? left.value : din;
    end
  end

  assign link.value = value;
  assign link.occ   = occ;
  assign link.gt    = gt;

endmodule

// ----- hdl/insertion_sort_engine.sv -----
// Top level of the insertion sort engine: cell chain and batch control.
`timescale 1ns / 1ps
`include "insertion_sort_engine_defines.svh"

// Streaming insertion sorter built as a chain of CAPACITY cells.
// Input channel (in_valid/in_ready, value, last): one signed value per
// transfer. Each value is compared against every cell at once and slots into
// place in the same cycle, so a batch is taken at one value per cycle.
// Equal values keep arrival order. A value that arrives when all cells are
// occupied is dropped and the batch is marked as overflowed.
// The transfer with last set closes the batch; the first result is offered
// on the next cycle. The chain then shifts towards cell 0, one result per
// output transfer (out_valid/out_ready, sorted_value, end_of_batch,
// overflow), smallest first, with end_of_batch on the final one. Results
// come straight from the register of cell 0.
// A batch of n values thus yields min(n, CAPACITY) results, and the input
// is held off (in_ready low) while the batch drains. When the receiver
// stalls, the chain holds and the offered result stays unchanged.
// Reset clears every occupied bit, the overflow mark and returns the block
// to accepting input; stored values need no clearing.
module insertion_sort_engine import ise_pkg::*; #(
  parameter int CAPACITY = ISE_CAPACITY
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] value,
  input  logic                     last,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] sorted_value,
  output logic                     end_of_batch,
  output logic                     overflow
);

  typedef enum logic [1:0] {
    ST_FILL  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  localparam logic [CAPACITY-1:0] OneVec = {{(CAPACITY-1){1'b0}}, 1'b1};

  state_t                state;
  state_t                state_next;
  logic                  dropped;
  cell_ctrl_t            ctrl;
  cell_link_t            links [CAPACITY];
  cell_link_t            head;
  cell_link_t            tail;
  logic [CAPACITY-1:0]   occ_vec;
  logic                  full;
  logic                  in_xfer;
  logic                  out_xfer;

  assign in_ready = (state == ST_FILL);
  assign in_xfer  = in_valid && in_ready;
  assign full     = links[CAPACITY-1].occ;
  assign out_valid = (state == ST_DRAIN) && links[0].occ;
  assign out_xfer  = out_valid && out_ready;

  // Insert unless every cell is taken; advance the chain on each output transfer.
  assign ctrl.insert = in_xfer && !full;
  assign ctrl.shift  = out_xfer;

  // Cell 0 sees an occupied, never-greater neighbour above it.
  assign head.value = '0;
  assign head.occ   = 1'b1;
  assign head.gt    = 1'b0;
  // The cell at the end pulls in an empty slot when draining.
  assign tail.value = '0;
  assign tail.occ   = 1'b0;
  assign tail.gt    = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_link_t left_l;
    cell_link_t right_l;
    if (i == 0) begin : g_first
      assign left_l = head;
    end else begin : g_mid_l
      assign left_l = links[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign right_l = tail;
    end else begin : g_mid_r
      assign right_l = links[i+1];
    end
    ise_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctrl  (ctrl),
      .din   (value),
      .left  (left_l),
      .right (right_l),
      .link  (links[i])
    );
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      occ_vec[i] = links[i].occ;
    end
  end

  // Result taken from the head of the chain.
  assign sorted_value = links[0].value;
  assign end_of_batch = !links[1].occ;
  assign overflow     = dropped;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_FILL: begin
        if (in_xfer && last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_xfer && end_of_batch) begin
          state_next = ST_FILL;
        end
      end
      default: state_next = ST_FILL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_FILL;
      dropped <= 1'b0;
    end else begin
      state <= state_next;
      // Mark the batch when a value is dropped; clear once it has drained.
      if (in_xfer && full) begin
        dropped <= 1'b1;
      end else if (out_xfer && end_of_batch) begin
        dropped <= 1'b0;
      end
    end
  end

  `ISE_ASSERT_NOW(a_no_overlap, in_ready, !out_valid, "input open while draining")
  `ISE_ASSERT_NXT(a_drain_starts, in_xfer && last, out_valid,
                  "no result after closing transfer")
  `ISE_ASSERT_NOW(a_occ_prefix, 1'b1, (occ_vec & (occ_vec + OneVec)) == '0,
                  "occupied cells not contiguous from cell 0")
  `ISE_ASSERT_NXT(a_batch_done, out_xfer && end_of_batch, in_ready && (occ_vec == '0),
                  "chain not empty after final result")

endmodule
